### hw/rtl/urza_pkg.sv
package urza_pkg;

  // item field widths
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned AVG_W     = 15;
  localparam int unsigned ZONE_W    = 2;
  localparam int unsigned FILL_W    = 8;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_FIELD_W = AVG_W + ZONE_W + FILL_W + 1;
  localparam int unsigned OUT_TDATA_W = 32;

  // pulse width to 1/256 inch: (us * 1777) >> 10
  localparam int unsigned DIST_MUL_W  = 11;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = 11'd1777;
  localparam int unsigned DIST_SHIFT  = 10;
  localparam int unsigned DIST_PROD_W = PULSE_W + DIST_MUL_W;
  localparam int unsigned DIST_W      = DIST_PROD_W - DIST_SHIFT;

  // bar geometry
  localparam int unsigned BAR_WIDTH = 62;
  localparam logic [FILL_W-1:0] BAR_SPAN = FILL_W'(BAR_WIDTH - 2);
  localparam int unsigned FILL_PROD_W = CFG_W + FILL_W;

  // bar divider divisor width
  localparam int unsigned DIV_W = 8;

  // register reset values
  localparam logic [CFG_W-1:0] FAR_RST  = 7'd24;
  localparam logic [CFG_W-1:0] STOP_RST = 7'd4;
  localparam logic [CFG_W-1:0] MAX_RST  = 7'd72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAR  = 2'd0,
    CFG_STOP = 2'd1,
    CFG_MAX  = 2'd2
  } cfg_idx_e;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_FAR  = 2'd0,
    ZONE_NEAR = 2'd1,
    ZONE_STOP = 2'd2
  } zone_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_STORE,
    ST_AVG,
    ST_PROD,
    ST_FILL_GO,
    ST_FILL_WAIT,
    ST_SEND
  } ctrl_state_e;

  typedef struct packed {
    logic     load_in;
    logic     scale;
    logic     store;
    logic     div_start;
    logic     take_avg;
    logic     prod;
    logic     take_fill;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

### hw/rtl/urza_div.sv
module urza_div import urza_pkg::*; #(
  parameter int unsigned N = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [N-1:0]     dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [N-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [N-1:0]     dvd_q, dvd_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dvd_q[N-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CNT_W'(N);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
      dvd_d  = {dvd_q[N-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

### hw/rtl/urza_ctrl.sv
module urza_ctrl import urza_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_STORE;
      ST_STORE:     state_d = ST_AVG;
      ST_AVG:       state_d = ST_PROD;
      ST_PROD:      state_d = ST_FILL_GO;
      ST_FILL_GO:   state_d = ST_FILL_WAIT;
      ST_FILL_WAIT: if (sts_i.div_done) state_d = ST_SEND;
      ST_SEND:      if (sts_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_SCALE:     cmd_o.scale = 1'b1;
      ST_STORE:     cmd_o.store = 1'b1;
      ST_AVG:       cmd_o.take_avg = 1'b1;
      ST_PROD:      cmd_o.prod = 1'b1;
      ST_FILL_GO:   cmd_o.div_start = 1'b1;
      ST_FILL_WAIT: cmd_o.take_fill = sts_i.div_done;
      ST_SEND:      cmd_o.load_out = sts_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/urza_datapath.sv
module urza_datapath import urza_pkg::*; #(
  parameter int unsigned NUM_SAMPLES = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [PULSE_W-1:0]   pulse_us_i,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [AVG_W-1:0]     avg_distance_o,
  output logic [ZONE_W-1:0]    zone_o,
  output logic [FILL_W-1:0]    bar_fill_o,
  output logic                 accepted_o
);

  localparam int unsigned IDX_W = $clog2(NUM_SAMPLES);
  localparam int unsigned SUM_W = AVG_W + $clog2(NUM_SAMPLES);

  // mean by reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int unsigned RECIP_SH   = SUM_W + $clog2(NUM_SAMPLES);
  localparam int unsigned RECIP_W    = SUM_W + 1;
  localparam int unsigned MEAN_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SH) + NUM_SAMPLES - 1) / NUM_SAMPLES);

  logic [CFG_W-1:0]       far_q, stop_q, max_q;
  logic [PULSE_W-1:0]     pulse_q;
  logic [DIST_W-1:0]      dist_q;
  logic [DIST_PROD_W-1:0] dist_prod;
  logic [AVG_W-1:0]       ring_q [NUM_SAMPLES];
  logic [IDX_W-1:0]       slot_q;
  logic [SUM_W-1:0]       sum_q;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic                   acc_q;
  logic                   take_ok;
  logic [AVG_W-1:0]       avg_q;
  logic [CFG_W-1:0]       whole;
  logic [FILL_PROD_W-1:0] fprod_q;
  logic [FILL_W-1:0]      fill_q;
  logic [ZONE_W-1:0]      zone_d;
  logic [DIV_W-1:0]       div_divisor;
  logic                   div_done;
  logic [FILL_PROD_W-1:0] div_quot;
  logic                   out_valid_q;
  logic [AVG_W-1:0]       out_avg_q;
  logic [ZONE_W-1:0]      out_zone_q;
  logic [FILL_W-1:0]      out_fill_q;
  logic                   out_acc_q;

  // config registers, upper index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_q  <= FAR_RST;
      stop_q <= STOP_RST;
      max_q  <= MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FAR:  far_q  <= cfg_data_i;
        CFG_STOP: stop_q <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign dist_prod = DIST_PROD_W'(pulse_q) * DIST_PROD_W'(DIST_MUL);

  // in range and nonzero goes into the ring
  assign take_ok = (dist_q != '0) && (dist_q < DIST_W'({max_q, 8'h00}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) pulse_q <= pulse_us_i;
    if (cmd_i.scale)   dist_q  <= dist_prod[DIST_PROD_W-1:DIST_SHIFT];
    if (cmd_i.store)   acc_q   <= take_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SAMPLES; i++) ring_q[i] <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.store && take_ok) begin
      ring_q[slot_q] <= dist_q[AVG_W-1:0];
      sum_q  <= sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(dist_q[AVG_W-1:0]);
      slot_q <= (slot_q == IDX_W'(NUM_SAMPLES - 1)) ? '0 : slot_q + IDX_W'(1);
    end
  end

  assign mean_prod = MEAN_PROD_W'(sum_q) * MEAN_PROD_W'(RECIP);

  // bar scaling divider
  assign div_divisor = DIV_W'(far_q);

  urza_div #(
    .N (FILL_PROD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (fprod_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign whole = (avg_q[AVG_W-1:8] > far_q) ? far_q : avg_q[AVG_W-1:8];

  always_comb begin
    if (avg_q >= AVG_W'({far_q, 8'h00})) begin
      zone_d = ZONE_FAR;
    end else if (avg_q <= AVG_W'({stop_q, 8'h00})) begin
      zone_d = ZONE_STOP;
    end else begin
      zone_d = ZONE_NEAR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_avg)  avg_q   <= mean_prod[RECIP_SH +: AVG_W];
    if (cmd_i.prod)      fprod_q <= FILL_PROD_W'(whole) * FILL_PROD_W'(BAR_SPAN);
    if (cmd_i.take_fill) begin
      fill_q <= (far_q == '0) ? BAR_SPAN : BAR_SPAN - div_quot[FILL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_avg_q  <= avg_q;
      out_zone_q <= zone_d;
      out_fill_q <= fill_q;
      out_acc_q  <= acc_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign avg_distance_o = out_avg_q;
  assign zone_o         = out_zone_q;
  assign bar_fill_o     = out_fill_q;
  assign accepted_o     = out_acc_q;

endmodule

### hw/rtl/ultrasonic_range_average_zone_top.sv
// ultrasonic range averaging and zone classifier. each input beat carries one
// echo pulse width in microseconds; it is scaled to 1/256 inch as
// (us * 1777) >> 10, and a nonzero reading below the max range (whole inches)
// is written into a NUM_SAMPLES-entry ring (cleared at reset, wrapping write
// slot). every input beat yields exactly one output beat with the ring mean,
// the zone (0 far, 1 near, 2 stop; far wins), the bar fill width and a flag
// telling whether the reading went into the ring. one item is in flight at a
// time: the next beat is taken only once the current item is loaded into
// the output register. each item is scaled, offered to the ring, averaged and
// then scaled for the bar: the product inches * span is registered and a
// bit-serial divider divides it by the far threshold, one quotient bit per
// cycle over the 15-bit product; the ring mean is a reciprocal multiply
// whose result is registered first. a finished result waits in the output
// register while the next item is accepted; a second finished result holds
// the input off until the waiting output beat is taken. config registers are
// written through a plain write port (0 far threshold, 1 stop threshold,
// 2 max range, 7 bits each) and must only be written while the block is idle.
module ultrasonic_range_average_zone_top import urza_pkg::*; #(
  parameter int unsigned NUM_SAMPLES = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] pulse_us
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [14:0] avg_distance, [16:15] zone, [24:17] bar_fill, [25] accepted,
  // [31:26] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic [AVG_W-1:0]   avg_distance;
  logic [ZONE_W-1:0]  zone;
  logic [FILL_W-1:0]  bar_fill;
  logic               accepted;

  // sequencer: accept, scale, ring update, mean, bar divide, send
  urza_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ring, config registers, divider and output register
  urza_datapath #(
    .NUM_SAMPLES (NUM_SAMPLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pulse_us_i     (s_axis_tdata[PULSE_W-1:0]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .avg_distance_o (avg_distance),
    .zone_o         (zone),
    .bar_fill_o     (bar_fill),
    .accepted_o     (accepted)
  );

  // pack result fields, lowest field first, pad to 32 bits
  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), accepted, bar_fill, zone,
                         avg_distance};

endmodule

### hw/rtl/urza_checker.sv
module urza_checker import urza_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a held result beat keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // zone code stays within far, near, stop
  a_zone_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:15] != 2'd3)
    else $error("zone code out of range");

  // bar fill never exceeds the span
  a_fill_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[24:17] <= BAR_SPAN)
    else $error("bar fill beyond span");

endmodule

bind ultrasonic_range_average_zone_top urza_checker u_urza_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### bench/ultrasonic_range_average_zone_top_test.sv
`timescale 1ns / 1ps

module ultrasonic_range_average_zone_top_test;
  import urza_pkg::*;

  localparam time         CLK_PERIOD     = 12ns;
  localparam int unsigned RING_DEPTH     = 5;
  localparam int unsigned FILL_SPAN      = 60;    // bar width minus the two border pixels
  localparam int unsigned SCALE_MUL      = 1777;
  localparam int unsigned SCALE_SHIFT    = 10;
  localparam int unsigned IDLE_PCT       = 17;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // one output beat, split into its fields
  typedef struct {
    logic [AVG_W-1:0]  avg;
    zone_e             zone;
    logic [FILL_W-1:0] fill;
    logic              accepted;
  } range_report_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] pulse_us
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [14:0] avg, [16:15] zone, [24:17] fill, [25] accepted

  // predictor copy of the block state and registers
  logic [AVG_W-1:0] ring_model [RING_DEPTH];
  int unsigned      slot_model;
  logic [17:0]      sum_model;
  logic [CFG_W-1:0] far_in;
  logic [CFG_W-1:0] stop_in;
  logic [CFG_W-1:0] max_in;

  range_report_t expected_reports[$];
  int unsigned   fail_count;
  int unsigned   quiet_cycles;

  // idling knobs, flipped by the test tasks
  bit tx_gaps_on;
  bit rx_gaps_on;
  bit rx_hold_pending;
  int unsigned rx_hold_left;

  ultrasonic_range_average_zone_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // scale the pulse, update the ring and work out the report for one reading
  function automatic range_report_t predict_report(input logic [PULSE_W-1:0] us);
    range_report_t rep;
    int unsigned   dist_val;
    int unsigned   avg;
    int unsigned   whole;
    dist_val = (int'(us) * SCALE_MUL) >> SCALE_SHIFT;
    rep.accepted = 1'b0;
    if (dist_val != 0 && dist_val < max_in * 256) begin
      if (slot_model >= RING_DEPTH) slot_model = 0;
      sum_model = 18'(sum_model - ring_model[slot_model] + dist_val);
      ring_model[slot_model] = dist_val[AVG_W-1:0];
      slot_model = (slot_model + 1 >= RING_DEPTH) ? 0 : slot_model + 1;
      rep.accepted = 1'b1;
    end
    avg = sum_model / RING_DEPTH;
    rep.avg = avg[AVG_W-1:0];
    // far wins over stop when the thresholds overlap
    if (avg >= far_in * 256) rep.zone = ZONE_FAR;
    else if (avg <= stop_in * 256) rep.zone = ZONE_STOP;
    else rep.zone = ZONE_NEAR;
    whole = avg >> 8;
    if (whole > far_in) whole = 32'(far_in);
    if (far_in == 0) rep.fill = FILL_W'(FILL_SPAN);
    else rep.fill = FILL_W'(FILL_SPAN - (whole * FILL_SPAN) / far_in);
    return rep;
  endfunction

  // input side: every accepted pulse beat queues its expected report
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) begin
      expected_reports.push_back(predict_report(s_axis_tdata[PULSE_W-1:0]));
    end
  end

  // output side: compare each report beat with the oldest expectation
  always @(posedge clk_i) begin
    range_report_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("report beat with nothing expected: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tdata[14:0] !== want.avg) begin
          $error("avg_distance: expected %0d, got %0d", want.avg, m_axis_tdata[14:0]);
          fail_count++;
        end
        if (m_axis_tdata[16:15] !== want.zone) begin
          $error("zone: expected %0d, got %0d", want.zone, m_axis_tdata[16:15]);
          fail_count++;
        end
        if (m_axis_tdata[24:17] !== want.fill) begin
          $error("bar_fill: expected %0d, got %0d", want.fill, m_axis_tdata[24:17]);
          fail_count++;
        end
        if (m_axis_tdata[25] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, m_axis_tdata[25]);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here on request
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_hold_pending) begin
      rx_hold_pending = 1'b0;
      rx_hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_gaps_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog: too long without any beat on either side ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one pulse beat; valid stays high into the next call unless a gap is taken
  task automatic send_pulse(input logic [PULSE_W-1:0] us);
    while (tx_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= us;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
  endtask

  // stop sending and let every outstanding report come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    // wait for a clock edge so the last accepted beat is surely queued
    @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FAR:  far_in = val;
      CFG_STOP: stop_in = val;
      CFG_MAX:  max_in = val;
      default: ;  // unused index, the block ignores it
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] far_v, input logic [CFG_W-1:0] stop_v,
                              input logic [CFG_W-1:0] max_v);
    write_reg(CFG_FAR, far_v);
    write_reg(CFG_STOP, stop_v);
    write_reg(CFG_MAX, max_v);
  endtask

  // random pulse, mostly readings that land in the ring
  function automatic logic [PULSE_W-1:0] pick_pulse();
    int unsigned roll;
    int unsigned lim_us;
    roll   = $urandom_range(99);
    lim_us = (max_in * 256 * 1024) / SCALE_MUL;
    if (roll < 6) return '0;
    if (roll < 16) return PULSE_W'($urandom);
    // straddle the max range rejection point
    if (roll < 28) return PULSE_W'($urandom_range(lim_us + 3, (lim_us > 3) ? lim_us - 3 : 0));
    return PULSE_W'($urandom_range(max_in * 148 + 8, 1));
  endfunction

  // reset register values, timeout, full scale pulse, max range boundary
  task automatic test_reset_defaults();
    send_pulse(16'd0);
    send_pulse(16'd1);
    send_pulse(16'hFFFF);
    send_pulse(16'd100);
    send_pulse(16'd1000);
    send_pulse(16'd2000);
    send_pulse(16'd5000);
    send_pulse(16'd10621);  // just below 72 inches
    send_pulse(16'd10622);  // exactly 72 inches, rejected
    send_pulse(16'd600);
    wait_idle();
  endtask

  task automatic test_special_cases();
    // zero max range rejects everything
    program_regs(7'd24, 7'd4, 7'd0);
    send_pulse(16'd500);
    send_pulse(16'd1);
    wait_idle();
    // zero far threshold: always far, bar full
    program_regs(7'd0, 7'd4, 7'd72);
    send_pulse(16'd3000);
    send_pulse(16'd200);
    wait_idle();
    // stop above far: far wins, stop only below far
    program_regs(7'd10, 7'd40, 7'd72);
    send_pulse(16'd800);
    send_pulse(16'd4000);
    send_pulse(16'd300);
    wait_idle();
    // an unused index must leave all registers alone
    write_reg(CFG_UNUSED_IDX, 7'h7F);
    send_pulse(16'd1500);
    wait_idle();
    // widest settings
    program_regs(7'd72, 7'd72, 7'd127);
    send_pulse(16'd18700);  // just below 127 inches
    send_pulse(16'd22000);  // beyond 127 inches
    send_pulse(16'hFFFF);
    send_pulse(16'd18734);
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: program_regs(7'd72, 7'd72, 7'd127);
        1: program_regs(7'd1, 7'd0, 7'd1);
        2: program_regs(7'd24, 7'd4, 7'd72);
        default: program_regs(CFG_W'($urandom_range(72, 1)), CFG_W'($urandom_range(72, 0)),
                              CFG_W'($urandom_range(127, 1)));
      endcase
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
      repeat (100) send_pulse(pick_pulse());
      wait_idle();
    end
  endtask

  // back to back beats with no idling on either side
  task automatic test_steady_stream();
    program_regs(7'd36, 7'd8, 7'd100);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (100) send_pulse(pick_pulse());
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    program_regs(7'd48, 7'd12, 7'd64);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    rx_hold_pending = 1'b1;
    repeat (40) send_pulse(pick_pulse());
    wait_idle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    tx_gaps_on      = 1'b1;
    rx_gaps_on      = 1'b1;
    rx_hold_pending = 1'b0;
    rx_hold_left    = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    // predictor starts from the reset state
    foreach (ring_model[i]) ring_model[i] = '0;
    slot_model = 0;
    sum_model  = '0;
    far_in     = FAR_RST;
    stop_in    = STOP_RST;
    max_in     = MAX_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_special_cases();
    test_random_phases();
    test_steady_stream();
    test_output_stall();

    // catch any stray beat after the last report
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
